// File: rtl/assert_macros.svh
// Assertion macros shared by the yuv420 to uyvy writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define YUW_ASSERT(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Implication checked in the same cycle outside reset.
`define YUW_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/yuw_pkg.sv
// Package: constants, register indexes and shared types of the uyvy writer.
package yuw_pkg;

   localparam int DEF_MAX_BLOCKS = 64;
   localparam int DEF_ADDR_BITS  = 23;

   localparam int ADDR_W      = 23;
   localparam int COUNT_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int STRIDE_W    = 12;
   localparam int POS_W       = 9;
   localparam int JQ_DEPTH    = 2;

   localparam logic [POS_W-1:0] BLOCK_BYTES = 9'd384;
   localparam logic [POS_W-1:0] LUMA_START  = 9'd128;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKS_ACROSS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKS_DOWN   = 2'd2;

   typedef struct packed {
      logic [7:0] data;
      logic [4:0] c_addr;
      logic [5:0] y_addr;
      logic [1:0] u_we;
      logic [1:0] v_we;
      logic [3:0] y_we;
   } store_wr_type;

   typedef struct packed {
      logic       en;
      logic [4:0] c_addr;
      logic [5:0] y_addr;
   } store_rd_type;

   typedef struct packed {
      logic [3:0][7:0] y;
      logic [1:0][7:0] u;
      logic [1:0][7:0] v;
   } store_q_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   origin;
      logic [STRIDE_W-1:0] stride;
      logic                last_frame;
   } job_type;

endpackage

// File: rtl/yuv420_macroblock_to_uyvy_writer_unit.sv
// A block's words follow its 384th byte through the job queue, store read and output register.
// Throughput: one byte per cycle while req_stall is low; after each block's last byte intake
// stalls while the job is queued and the emitter reads the stores.
// Words leave one per cycle while rsp_stall is low, through a registered output.
// Reset clears position, registers (counts to one) and handshake state; stores are not cleared.
module yuv420_macroblock_to_uyvy_writer_unit #(
   parameter int MAX_BLOCKS = yuw_pkg::DEF_MAX_BLOCKS,
   parameter int ADDR_BITS  = yuw_pkg::DEF_ADDR_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [yuw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [yuw_pkg::ADDR_W-1:0]      csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [yuw_pkg::ADDR_W-1:0]      rsp_write_address,
   output logic [63:0]                     rsp_write_data,
   output logic                            rsp_last_of_block,
   output logic                            rsp_frame_done
);
   import yuw_pkg::*;

   store_wr_type store_wr;
   store_rd_type store_rd;
   store_q_type  store_q;
   job_type      push_job, head_job;
   logic         job_push, job_pop, job_valid, back_busy, hold;

   assign hold = job_valid || back_busy;

   yuw_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .hold             (hold),
      .store_wr         (store_wr),
      .job_push         (job_push),
      .job              (push_job)
   );

   yuw_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .job_valid (job_valid),
      .job       (head_job)
   );

   for (genvar i = 0; i < 4; i++) begin : g_luma
      yuw_ram #(.WIDTH(8), .DEPTH(64)) u_ram (
         .clock   (clock),
         .wr_en   (store_wr.y_we[i]),
         .wr_addr (store_wr.y_addr),
         .wr_data (store_wr.data),
         .rd_en   (store_rd.en),
         .rd_addr (store_rd.y_addr),
         .rd_data (store_q.y[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_chroma
      yuw_ram #(.WIDTH(8), .DEPTH(32)) u_ram_u (
         .clock   (clock),
         .wr_en   (store_wr.u_we[i]),
         .wr_addr (store_wr.c_addr),
         .wr_data (store_wr.data),
         .rd_en   (store_rd.en),
         .rd_addr (store_rd.c_addr),
         .rd_data (store_q.u[i])
      );
      yuw_ram #(.WIDTH(8), .DEPTH(32)) u_ram_v (
         .clock   (clock),
         .wr_en   (store_wr.v_we[i]),
         .wr_addr (store_wr.c_addr),
         .wr_data (store_wr.data),
         .rd_en   (store_rd.en),
         .rd_addr (store_rd.c_addr),
         .rd_data (store_q.v[i])
      );
   end

   yuw_back #(.ADDR_BITS(ADDR_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job               (head_job),
      .job_pop           (job_pop),
      .busy              (back_busy),
      .store_rd          (store_rd),
      .store_q           (store_q),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_frame_done    (rsp_frame_done)
   );
endmodule

// File: rtl/yuw_ram.sv
// Generic single write port RAM with registered read.
module yuw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/yuw_front.sv
// Front end: CSR registers, byte intake, store writes, block position and job generation.
`include "assert_macros.svh"
module yuw_front #(
   parameter int MAX_BLOCKS = yuw_pkg::DEF_MAX_BLOCKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [yuw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [yuw_pkg::ADDR_W-1:0]      csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            hold,
   output yuw_pkg::store_wr_type           store_wr,
   output logic                            job_push,
   output yuw_pkg::job_type                job
);
   import yuw_pkg::*;

   localparam int CW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BLOCKS);

   logic [ADDR_W-1:0]  base_ff;
   logic [COUNT_W-1:0] across_ff, down_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CW-1:0]      col_ff, col_in, row_ff, row_in;

   logic               accept, block_end, wrap, last_frame;
   logic [COUNT_W-1:0] across_eff, down_eff, col_inc, row_inc, row_new;
   logic [POS_W-1:0]   luma_idx;
   logic [13:0]        row_prod;

   assign req_stall = hold;
   assign accept    = req_valid && !hold;
   assign block_end = accept && (pos_ff == BLOCK_BYTES - 9'd1);

   always_comb begin
      priority if (across_ff == '0) begin
         across_eff = COUNT_W'(1);
      end else if (across_ff > MAX_COUNT) begin
         across_eff = MAX_COUNT;
      end else begin
         across_eff = across_ff;
      end
      priority if (down_ff == '0) begin
         down_eff = COUNT_W'(1);
      end else if (down_ff > MAX_COUNT) begin
         down_eff = MAX_COUNT;
      end else begin
         down_eff = down_ff;
      end
   end

   assign col_inc    = COUNT_W'(col_ff) + COUNT_W'(1);
   assign row_inc    = COUNT_W'(row_ff) + COUNT_W'(1);
   assign wrap       = col_inc >= across_eff;
   assign row_new    = wrap ? row_inc : COUNT_W'(row_ff);
   assign last_frame = row_new >= down_eff;

   assign row_prod = 14'(across_eff) * 14'(row_ff);

   assign job.origin     = base_ff + {row_prod, 9'b0} + ADDR_W'({col_ff, 5'b0});
   assign job.stride     = {across_eff, 5'b0};
   assign job.last_frame = last_frame;
   assign job_push       = block_end;

   assign luma_idx = pos_ff - LUMA_START;

   always_comb begin
      store_wr        = '0;
      store_wr.data   = req_data_byte;
      store_wr.c_addr = pos_ff[5:1];
      store_wr.y_addr = luma_idx[7:2];
      if (accept) begin
         unique case (pos_ff[8:6])
            3'd0:    store_wr.u_we = pos_ff[0] ? 2'b10 : 2'b01;
            3'd1:    store_wr.v_we = pos_ff[0] ? 2'b10 : 2'b01;
            default: store_wr.y_we = 4'b0001 << luma_idx[1:0];
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         pos_in = pos_ff + 9'd1;
      end
      if (block_end) begin
         pos_in = '0;
         col_in = wrap ? '0 : col_inc[CW-1:0];
         row_in = last_frame ? '0 : row_new[CW-1:0];
      end
      if (csr_write_enable && csr_index == CSR_BASE_ADDRESS) begin
         pos_in = '0;
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         across_ff <= COUNT_W'(1);
         down_ff   <= COUNT_W'(1);
         pos_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         pos_ff <= pos_in;
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BASE_ADDRESS:  base_ff   <= {csr_write_data[ADDR_W-1:3], 3'b000};
               CSR_BLOCKS_ACROSS: across_ff <= csr_write_data[COUNT_W-1:0];
               CSR_BLOCKS_DOWN:   down_ff   <= csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   `YUW_ASSERT(a_pos_range, pos_ff < BLOCK_BYTES, "byte position past end of macroblock")
endmodule

// File: rtl/yuw_job_queue.sv
// Short job queue between the intake front end and the word emitter.
`include "assert_macros.svh"
module yuw_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  yuw_pkg::job_type push_job,
   input  logic             pop,
   output logic             job_valid,
   output yuw_pkg::job_type job
);
   import yuw_pkg::*;

   localparam int PW = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;

   job_type         entries_ff [JQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]     count_ff;
   logic            do_push, do_pop;

   assign job_valid = count_ff != '0;
   assign job       = entries_ff[rd_ptr_ff];
   assign do_push   = push && (count_ff != (PW+1)'(JQ_DEPTH));
   assign do_pop    = pop && job_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(JQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(JQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (PW+1)'(1);
            2'b01:   count_ff <= count_ff - (PW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   `YUW_ASSERT_IMP(a_no_overflow, push, count_ff != (PW+1)'(JQ_DEPTH), "job queue overflow")
endmodule

// File: rtl/yuw_back.sv
// Back end: reads the stores and emits the 64 packed words of a macroblock.
`include "assert_macros.svh"
module yuw_back #(
   parameter int ADDR_BITS = yuw_pkg::DEF_ADDR_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  yuw_pkg::job_type           job,
   output logic                       job_pop,
   output logic                       busy,
   output yuw_pkg::store_rd_type      store_rd,
   input  yuw_pkg::store_q_type       store_q,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [yuw_pkg::ADDR_W-1:0] rsp_write_address,
   output logic [63:0]                rsp_write_data,
   output logic                       rsp_last_of_block,
   output logic                       rsp_frame_done
);
   import yuw_pkg::*;

   localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << AW) - 64'd1);

   logic                busy_ff, last_frame_ff;
   logic [5:0]          k_ff;
   logic [ADDR_W-1:0]   row_base_ff;
   logic [STRIDE_W-1:0] stride_ff;

   logic                s1_ff, s1_last_ff, s1_done_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;

   logic                rsp_valid_ff, rsp_last_ff, rsp_done_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [63:0]         rsp_data_ff;

   logic                issue, s1_move;

   assign job_pop = job_valid && !busy_ff;
   assign busy    = busy_ff;
   assign s1_move = s1_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue   = busy_ff && (!s1_ff || s1_move);

   assign store_rd.en     = issue;
   assign store_rd.y_addr = {k_ff[5], k_ff[1], k_ff[4:2], k_ff[0]};
   assign store_rd.c_addr = {k_ff[5:3], k_ff[1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (job_pop) begin
            busy_ff <= 1'b1;
         end else if (issue && k_ff == 6'd63) begin
            busy_ff <= 1'b0;
         end
         if (issue) begin
            s1_ff <= 1'b1;
         end else if (s1_move) begin
            s1_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         k_ff          <= '0;
         row_base_ff   <= job.origin;
         stride_ff     <= job.stride;
         last_frame_ff <= job.last_frame;
      end else if (issue) begin
         k_ff <= k_ff + 6'd1;
         if (k_ff[1:0] == 2'd3) begin
            row_base_ff <= row_base_ff + ADDR_W'(stride_ff);
         end
      end
      if (issue) begin
         s1_addr_ff <= row_base_ff + ADDR_W'({k_ff[1:0], 3'b000});
         s1_last_ff <= k_ff == 6'd63;
         s1_done_ff <= (k_ff == 6'd63) && last_frame_ff;
      end
      if (s1_move) begin
         rsp_addr_ff <= s1_addr_ff & ADDR_MASK;
         rsp_last_ff <= s1_last_ff;
         rsp_done_ff <= s1_done_ff;
         rsp_data_ff <= {store_q.y[3], store_q.v[1], store_q.y[2], store_q.u[1],
                         store_q.y[1], store_q.v[0], store_q.y[0], store_q.u[0]};
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_write_data    = rsp_data_ff;
   assign rsp_last_of_block = rsp_last_ff;
   assign rsp_frame_done    = rsp_done_ff;

   `YUW_ASSERT_IMP(a_no_read_overrun, s1_ff && !s1_move, !issue, "store read overwrote held word")
   `YUW_ASSERT_IMP(a_done_is_last, rsp_valid_ff && rsp_done_ff, rsp_last_ff,
                   "frame end not on last word of block")
endmodule
